// ===== design/efcc_pkg.sv =====
// Shared types and constants for the Ethernet frame class counters.
package efcc_pkg;

	localparam int MAX_FRAME  = 65536;
	localparam int LEN_W      = 17;
	localparam int CNT_W      = 64;
	localparam int N_COUNTERS = 11;

	localparam logic MODE_FRAME = 1'b0;
	localparam logic MODE_READ  = 1'b1;

	localparam logic KIND_SUMMARY = 1'b0;
	localparam logic KIND_READ    = 1'b1;

	localparam logic [3:0] C_L2_FRAMES = 4'd0;
	localparam logic [3:0] C_L2_BYTES  = 4'd1;
	localparam logic [3:0] C_L3_FRAMES = 4'd2;
	localparam logic [3:0] C_L3_BYTES  = 4'd3;
	localparam logic [3:0] C_ARP       = 4'd4;
	localparam logic [3:0] C_IP        = 4'd5;
	localparam logic [3:0] C_L4_FRAMES = 4'd6;
	localparam logic [3:0] C_L4_BYTES  = 4'd7;
	localparam logic [3:0] C_ICMP      = 4'd8;
	localparam logic [3:0] C_TCP       = 4'd9;
	localparam logic [3:0] C_UDP       = 4'd10;

	typedef enum logic [2:0] {
		CLS_IGNORED  = 3'd0,
		CLS_ARP      = 3'd1,
		CLS_IP_OTHER = 3'd2,
		CLS_ICMP     = 3'd3,
		CLS_TCP      = 3'd4,
		CLS_UDP      = 3'd5,
		CLS_OTHER    = 3'd6
	} frame_class_t;

	typedef struct packed {
		logic       mode;
		logic [7:0] data_byte;
		logic       last_byte;
		logic [3:0] counter_index;
	} in_item_t;

	typedef struct packed {
		logic             result_kind;
		logic [2:0]       frame_class;
		logic [LEN_W-1:0] frame_length;
		logic [CNT_W-1:0] counter_value;
	} out_item_t;

	typedef struct packed {
		frame_class_t     frame_class;
		logic [LEN_W-1:0] frame_length;
		logic [LEN_W-1:0] l3_len;
		logic [LEN_W-1:0] l4_len;
	} frame_sum_t;

endpackage

// ===== design/ethernet_frame_class_counters_top.sv =====
// Top level of the Ethernet frame class counters: input stage, counter bank and result register.
//
//  Channel  Handshake             Payload    Moves
//  input    in_valid / in_ready   in_data    frame byte or counter read request
//  output   out_valid / out_ready out_data   end-of-frame summary or counter value
//
//  One transaction is taken every cycle unless a blocked result stalls it; each passes
//  an input register, then classification and a 64-bit counter add, into the result register.
//  Reset clears the frame state, all eleven counters and both valid flags at once.
//  A stalled output holds only transactions that give a result; other bytes still pass.
module ethernet_frame_class_counters_top import efcc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	logic             valid_s1;
	in_item_t         item_s1;
	logic             has_result_s1;
	logic             out_free;
	logic             s1_fire;
	logic             frame_en;
	logic             frame_end;
	frame_sum_t       sum;
	logic [CNT_W-1:0] bank_q [N_COUNTERS];
	logic [LEN_W-1:0] amt [N_COUNTERS];
	logic [CNT_W-1:0] read_value;
	out_item_t        result;
	logic             out_valid_q;
	out_item_t        out_q;

	assign has_result_s1 = (item_s1.mode == MODE_READ) || item_s1.last_byte;
	assign out_free      = !out_valid_q || out_ready;
	assign s1_fire       = valid_s1 && (!has_result_s1 || out_free);
	assign in_ready      = !valid_s1 || s1_fire;
	assign frame_en      = s1_fire && (item_s1.mode == MODE_FRAME);
	assign frame_end     = frame_en && item_s1.last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	efcc_frame_track u_frame_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (frame_en),
		.data_byte (item_s1.data_byte),
		.last_byte (item_s1.last_byte),
		.sum       (sum)
	);

	always_comb begin
		for (int i = 0; i < N_COUNTERS; i++) begin
			amt[i] = '0;
		end
		if (frame_end) begin
			case (sum.frame_class)
				CLS_ARP, CLS_IP_OTHER, CLS_ICMP, CLS_TCP, CLS_UDP, CLS_OTHER: begin
					amt[C_L2_FRAMES] = LEN_W'(1);
					amt[C_L2_BYTES]  = sum.frame_length;
				end
				default: ;
			endcase
			case (sum.frame_class)
				CLS_ARP, CLS_IP_OTHER, CLS_ICMP, CLS_TCP, CLS_UDP: begin
					amt[C_L3_FRAMES] = LEN_W'(1);
					amt[C_L3_BYTES]  = sum.l3_len;
				end
				default: ;
			endcase
			case (sum.frame_class)
				CLS_ICMP, CLS_TCP, CLS_UDP: begin
					amt[C_L4_FRAMES] = LEN_W'(1);
					amt[C_L4_BYTES]  = sum.l4_len;
				end
				default: ;
			endcase
			case (sum.frame_class)
				CLS_ARP:                               amt[C_ARP]  = LEN_W'(1);
				CLS_IP_OTHER, CLS_ICMP, CLS_TCP, CLS_UDP: amt[C_IP] = LEN_W'(1);
				default: ;
			endcase
			case (sum.frame_class)
				CLS_ICMP: amt[C_ICMP] = LEN_W'(1);
				CLS_TCP:  amt[C_TCP]  = LEN_W'(1);
				CLS_UDP:  amt[C_UDP]  = LEN_W'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N_COUNTERS; i++) begin
				bank_q[i] <= '0;
			end
		end else if (frame_end) begin
			for (int i = 0; i < N_COUNTERS; i++) begin
				bank_q[i] <= bank_q[i] + CNT_W'(amt[i]);
			end
		end
	end

	assign read_value = (item_s1.counter_index < 4'(N_COUNTERS)) ?
		bank_q[item_s1.counter_index] : '0;

	always_comb begin
		if (item_s1.mode == MODE_READ) begin
			result.result_kind   = KIND_READ;
			result.frame_class   = CLS_IGNORED;
			result.frame_length  = '0;
			result.counter_value = read_value;
		end else begin
			result.result_kind   = KIND_SUMMARY;
			result.frame_class   = sum.frame_class;
			result.frame_length  = sum.frame_length;
			result.counter_value = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && has_result_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && has_result_s1) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_ready_only_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && has_result_s1 && out_valid_q && !out_ready))
		else $error("input stalled without a blocked result");

	a_counted_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(frame_end && sum.frame_class != CLS_IGNORED)
		|=> bank_q[C_L2_FRAMES] == $past(bank_q[C_L2_FRAMES]) + CNT_W'(1))
		else $error("counted frame did not advance the L2 frame counter");

	a_read_leaves_bank: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && item_s1.mode == MODE_READ)
		|=> bank_q[C_L2_BYTES] == $past(bank_q[C_L2_BYTES]))
		else $error("counter read changed the counter bank");

	a_reply_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.result_kind == KIND_READ)
		|-> (out_q.frame_class == CLS_IGNORED && out_q.frame_length == '0))
		else $error("read reply carries frame fields");

endmodule

// ===== design/efcc_frame_track.sv =====
// Per-frame header tracking and classification of the frame that ends with this byte.
module efcc_frame_track import efcc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output frame_sum_t sum
);

	localparam logic [LEN_W-1:0] POS_SRC_MAC = LEN_W'(6);
	localparam logic [LEN_W-1:0] POS_ETYPE_L = LEN_W'(12);
	localparam logic [LEN_W-1:0] POS_ETYPE_H = LEN_W'(13);
	localparam logic [LEN_W-1:0] POS_IHL     = LEN_W'(14);
	localparam logic [LEN_W-1:0] POS_PROTO   = LEN_W'(23);
	localparam logic [LEN_W-1:0] ETH_HDR_LEN = LEN_W'(14);
	localparam logic [15:0]      ETYPE_ARP   = 16'h0608;
	localparam logic [15:0]      ETYPE_IPV4  = 16'h0008;
	localparam logic [7:0]       PROTO_ICMP  = 8'd1;
	localparam logic [7:0]       PROTO_TCP   = 8'd6;
	localparam logic [7:0]       PROTO_UDP   = 8'd17;

	logic [LEN_W-1:0] pos_q, pos_n;
	logic             dst_nz_q, dst_nz_n;
	logic             src_nz_q, src_nz_n;
	logic [15:0]      etype_q, etype_n;
	logic [3:0]       ihl_q, ihl_n;
	logic [7:0]       proto_q, proto_n;
	logic             byte_nz;
	logic [LEN_W-1:0] ip_hdr_len;

	assign byte_nz = (data_byte != 8'd0);

	always_comb begin
		pos_n    = (pos_q < LEN_W'(MAX_FRAME)) ? pos_q + LEN_W'(1) : pos_q;
		dst_nz_n = dst_nz_q | ((pos_q < POS_SRC_MAC) & byte_nz);
		src_nz_n = src_nz_q | ((pos_q >= POS_SRC_MAC) & (pos_q < POS_ETYPE_L) & byte_nz);
		etype_n  = etype_q;
		ihl_n    = ihl_q;
		proto_n  = proto_q;
		if (pos_q == POS_ETYPE_L) begin
			etype_n[7:0] = data_byte;
		end
		if (pos_q == POS_ETYPE_H) begin
			etype_n[15:8] = data_byte;
		end
		if (pos_q == POS_IHL) begin
			ihl_n = data_byte[3:0];
		end
		if (pos_q == POS_PROTO) begin
			proto_n = data_byte;
		end
	end

	assign ip_hdr_len = {{(LEN_W-6){1'b0}}, ihl_n, 2'b00};

	always_comb begin
		sum.frame_length = pos_n;
		sum.l3_len       = (pos_n > ETH_HDR_LEN) ? pos_n - ETH_HDR_LEN : '0;
		sum.l4_len       = (sum.l3_len > ip_hdr_len) ? sum.l3_len - ip_hdr_len : '0;
		if (!dst_nz_n && !src_nz_n) begin
			sum.frame_class = CLS_IGNORED;
		end else if (etype_n == ETYPE_ARP) begin
			sum.frame_class = CLS_ARP;
		end else if (etype_n != ETYPE_IPV4) begin
			sum.frame_class = CLS_OTHER;
		end else if (proto_n == PROTO_ICMP) begin
			sum.frame_class = CLS_ICMP;
		end else if (proto_n == PROTO_TCP) begin
			sum.frame_class = CLS_TCP;
		end else if (proto_n == PROTO_UDP) begin
			sum.frame_class = CLS_UDP;
		end else begin
			sum.frame_class = CLS_IP_OTHER;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			dst_nz_q <= 1'b0;
			src_nz_q <= 1'b0;
			etype_q  <= '0;
			ihl_q    <= '0;
			proto_q  <= '0;
		end else if (en) begin
			if (last_byte) begin
				pos_q    <= '0;
				dst_nz_q <= 1'b0;
				src_nz_q <= 1'b0;
				etype_q  <= '0;
				ihl_q    <= '0;
				proto_q  <= '0;
			end else begin
				pos_q    <= pos_n;
				dst_nz_q <= dst_nz_n;
				src_nz_q <= src_nz_n;
				etype_q  <= etype_n;
				ihl_q    <= ihl_n;
				proto_q  <= proto_n;
			end
		end
	end

endmodule
